[rtl/ssid_pkg.sv]
// ssid_pkg: shared constants, status codes and cell control types for the
// sorted insertion list. No dependencies.
package ssid_pkg;

  localparam int STORE_DEPTH = 16;
  localparam int VAL_W       = 32;
  localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
  localparam int IDX_W       = $clog2(STORE_DEPTH);
  localparam int STAT_W      = 2;
  localparam int OUT_CNT_W   = 5;

  // result status codes
  localparam logic [STAT_W-1:0] ST_DONE      = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [STAT_W-1:0] ST_EMPTY     = 2'd3;

  // command codes
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_DELETE = 1'b1;

  // broadcast to every cell
  typedef struct packed {
    logic                    ins_en;  // accepted insert, store not full
    logic                    del_en;  // accepted delete, store not empty
    logic signed [VAL_W-1:0] value;
  } cell_ctrl_t;

  // per-cell position relative to the fill count
  typedef struct packed {
    logic valid;   // slot holds an entry
    logic at_end;  // first free slot
  } cell_pos_t;

endpackage

[rtl/ssid_cell.sv]
// ssid_cell: one slot of the sorted chain. Compares its entry with the
// broadcast word and shifts up or down with its neighbors. Uses ssid_pkg.
module ssid_cell (
  input  logic                               clk,
  input  ssid_pkg::cell_ctrl_t               ctrl,
  input  ssid_pkg::cell_pos_t                pos,
  input  logic                               found,
  input  logic signed [ssid_pkg::VAL_W-1:0]  below_entry,
  input  logic                               below_gt,
  input  logic                               below_seen,
  input  logic signed [ssid_pkg::VAL_W-1:0]  above_entry,
  input  logic                               above_eq,
  output logic signed [ssid_pkg::VAL_W-1:0]  entry,
  output logic                               gt,
  output logic                               eq,
  output logic                               seen
);
  import ssid_pkg::*;

  logic signed [VAL_W-1:0] entry_r;
  logic signed [VAL_W-1:0] entry_nxt;

  assign gt    = pos.valid && (entry_r > ctrl.value);
  assign eq    = pos.valid && (entry_r == ctrl.value);
  assign seen  = below_seen || eq;
  assign entry = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    if (ctrl.ins_en) begin
      if (below_gt) begin
        entry_nxt = below_entry;
      end else if (gt || pos.at_end) begin
        entry_nxt = ctrl.value;
      end
    end else if (ctrl.del_en && found) begin
      // topmost equal entry is dropped and everything above it moves down one slot
      if (seen && !(eq && above_eq)) begin
        entry_nxt = above_entry;
      end
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

[rtl/sorted_stack_insert_delete.sv]
// sorted_stack_insert_delete: bounded ascending store of signed words.
// Result strobe is registered in the cycle after start; a new command every cycle.
// Throughput: one command per clock, set by one pass through the cell chain.
// Reset (rst_n low, synchronous): count and top cleared, no strobe; slot
// contents are not cleared. busy stays low and results cannot be stalled.
module sorted_stack_insert_delete (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  logic                                  in_command,
  input  logic signed [ssid_pkg::VAL_W-1:0]     in_operand_value,
  output logic                                  out_valid,
  output logic [ssid_pkg::STAT_W-1:0]           out_status,
  output logic [ssid_pkg::OUT_CNT_W-1:0]        out_entry_count,
  output logic signed [ssid_pkg::VAL_W-1:0]     out_largest_value
);
  import ssid_pkg::*;

  // Control registers
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic signed [VAL_W-1:0] top_r, top_nxt;
  logic                    out_valid_r;

  // Result payload registers
  logic [STAT_W-1:0]       out_status_r, status_nxt;
  logic [OUT_CNT_W-1:0]    out_count_r;
  logic signed [VAL_W-1:0] out_top_r;

  logic accept;
  logic is_full, is_empty, found;

  cell_ctrl_t ctrl;
  cell_pos_t  pos   [STORE_DEPTH];

  logic signed [VAL_W-1:0] cell_entry [STORE_DEPTH];
  logic                    cell_gt    [STORE_DEPTH];
  logic                    cell_eq    [STORE_DEPTH];
  logic                    cell_seen  [STORE_DEPTH];

  logic [CNT_W-1:0]        cnt_m2;
  logic signed [VAL_W-1:0] second_top;

  // Every command completes in one pass, so the port never pushes back.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign is_full  = (count_r == CNT_W'(STORE_DEPTH));
  assign is_empty = (count_r == '0);

  assign ctrl.ins_en = accept && (in_command == CMD_INSERT) && !is_full;
  assign ctrl.del_en = accept && (in_command == CMD_DELETE) && !is_empty;
  assign ctrl.value  = in_operand_value;

  // "seen" ripples up the chain; the top cell tells whether any slot matched
  assign found = cell_seen[STORE_DEPTH-1];

  // Chain of cells: slot 0 holds the smallest entry.
  for (genvar i = 0; i < STORE_DEPTH; i++) begin : g_cell
    logic signed [VAL_W-1:0] b_entry, a_entry;
    logic                    b_gt, b_seen, a_eq;

    assign pos[i].valid  = (CNT_W'(i) < count_r);
    assign pos[i].at_end = (CNT_W'(i) == count_r);

    if (i == 0) begin : g_bot
      assign b_entry = '0;
      assign b_gt    = 1'b0;
      assign b_seen  = 1'b0;
    end else begin : g_mid_lo
      assign b_entry = cell_entry[i-1];
      assign b_gt    = cell_gt[i-1];
      assign b_seen  = cell_seen[i-1];
    end

    if (i == STORE_DEPTH - 1) begin : g_top
      assign a_entry = '0;
      assign a_eq    = 1'b0;
    end else begin : g_mid_hi
      assign a_entry = cell_entry[i+1];
      assign a_eq    = cell_eq[i+1];
    end

    ssid_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .pos         (pos[i]),
      .found       (found),
      .below_entry (b_entry),
      .below_gt    (b_gt),
      .below_seen  (b_seen),
      .above_entry (a_entry),
      .above_eq    (a_eq),
      .entry       (cell_entry[i]),
      .gt          (cell_gt[i]),
      .eq          (cell_eq[i]),
      .seen        (cell_seen[i])
    );
  end

  // Entry just below the top; becomes the new top when the top is deleted.
  assign cnt_m2     = count_r - CNT_W'(2);
  assign second_top = cell_entry[cnt_m2[IDX_W-1:0]];

  // Count, top tracking and status
  always_comb begin
    count_nxt  = count_r;
    top_nxt    = top_r;
    status_nxt = ST_DONE;
    if (accept) begin
      if (in_command == CMD_INSERT) begin
        if (is_full) begin
          status_nxt = ST_FULL;
        end else begin
          count_nxt = count_r + CNT_W'(1);
          // equal words land above existing ones, so >= takes the top
          if (is_empty || (in_operand_value >= top_r)) begin
            top_nxt = in_operand_value;
          end
        end
      end else begin
        if (is_empty) begin
          status_nxt = ST_EMPTY;
        end else if (!found) begin
          status_nxt = ST_NOT_FOUND;
        end else begin
          count_nxt = count_r - CNT_W'(1);
          if (count_r == CNT_W'(1)) begin
            top_nxt = '0;
          end else if (top_r == in_operand_value) begin
            top_nxt = second_top;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      top_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      top_r       <= top_nxt;
      out_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_status_r <= status_nxt;
      out_count_r  <= OUT_CNT_W'(count_nxt);
      out_top_r    <= top_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_entry_count   = out_count_r;
  assign out_largest_value = out_top_r;

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(STORE_DEPTH))
    else $error("entry count above store depth");

  a_strobe_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid)
    else $error("accepted word produced no result strobe");

  a_empty_top_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && count_r == '0) |-> (out_largest_value == '0))
    else $error("empty store reports nonzero top");

  a_full_refused: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_FULL) |-> (count_r == CNT_W'(STORE_DEPTH)))
    else $error("insert refused while store not full");

endmodule

[test/store_check_pkg.sv]
`timescale 1ns / 100ps
// store_check_pkg: shadow copy of the sorted store and the queue of replies
// it predicts for each accepted command word. Depends on ssid_pkg (RTL).
package store_check_pkg;
  import ssid_pkg::*;

  typedef struct {
    logic [STAT_W-1:0]       status;
    logic [OUT_CNT_W-1:0]    count;
    logic signed [VAL_W-1:0] largest;
  } store_reply_t;

  class ordered_store_shadow;
    logic signed [VAL_W-1:0] slots [STORE_DEPTH];
    int                      held = 0;
    int                      mismatches = 0;
    store_reply_t            awaited_replies[$];

    // every failure is printed and counted
    function void flag(string msg);
      mismatches++;
      $display("%s", msg);
    endfunction

    function void note_command(logic cmd, logic signed [VAL_W-1:0] v);
      store_reply_t rep;
      int           pos;
      rep.status = ST_DONE;
      if (cmd == CMD_INSERT) begin
        if (held >= STORE_DEPTH) begin
          rep.status = ST_FULL;
        end else begin
          // land just above every entry <= v
          pos = held;
          while (pos > 0 && slots[pos-1] > v) pos--;
          for (int k = held; k > pos; k--) slots[k] = slots[k-1];
          slots[pos] = v;
          held++;
        end
      end else if (held == 0) begin
        rep.status = ST_EMPTY;
      end else begin
        // topmost equal entry goes
        pos = held;
        while (pos > 0 && slots[pos-1] != v) pos--;
        if (pos == 0) begin
          rep.status = ST_NOT_FOUND;
        end else begin
          for (int k = pos - 1; k + 1 < held; k++) slots[k] = slots[k+1];
          held--;
        end
      end
      rep.count   = held[OUT_CNT_W-1:0];
      rep.largest = (held > 0) ? slots[held-1] : '0;
      awaited_replies.push_back(rep);
    endfunction

    function void check_reply(logic [STAT_W-1:0] status, logic [OUT_CNT_W-1:0] count,
                              logic signed [VAL_W-1:0] largest);
      store_reply_t exp;
      if (awaited_replies.size() == 0) begin
        flag($sformatf("%0t: unexpected reply: status %0d count %0d top %0d",
                       $time, status, count, largest));
        return;
      end
      exp = awaited_replies.pop_front();
      if (status !== exp.status)
        flag($sformatf("%0t: status expected %0d, got %0d", $time, exp.status, status));
      if (count !== exp.count)
        flag($sformatf("%0t: entry_count expected %0d, got %0d", $time, exp.count, count));
      if (largest !== exp.largest)
        flag($sformatf("%0t: largest_value expected %0d, got %0d",
                       $time, exp.largest, largest));
    endfunction

    // random entry currently held, so deletes usually hit
    function logic signed [VAL_W-1:0] pick_held();
      if (held == 0) return $urandom;
      return slots[$urandom_range(0, held - 1)];
    endfunction

    function void flag_leftovers();
      while (awaited_replies.size() != 0) begin
        flag($sformatf("%0t: reply never came: status %0d count %0d top %0d", $time,
                       awaited_replies[0].status, awaited_replies[0].count,
                       awaited_replies[0].largest));
        void'(awaited_replies.pop_front());
      end
    endfunction
  endclass

endpackage

[test/sorted_stack_insert_delete_tb.sv]
`timescale 1ns / 100ps
// sorted_stack_insert_delete_tb: directed and random insert/delete words
// against the sorted store, checked by a shadow store.
// Depends on ssid_pkg, store_check_pkg and the sorted_stack_insert_delete RTL.
module sorted_stack_insert_delete_tb;
  import ssid_pkg::*;
  import store_check_pkg::*;

  localparam int WORD_COUNT  = 1850;
  // worst case: ~1850 words, each after the longest idle gap, stays well inside this limit
  localparam int CYCLE_LIMIT = 400000;
  localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  logic                    clk;
  logic                    rst_n;
  logic                    start;
  logic                    busy;
  logic                    in_command;
  logic signed [VAL_W-1:0] in_operand_value;
  logic                    out_valid;
  logic [STAT_W-1:0]       out_status;
  logic [OUT_CNT_W-1:0]    out_entry_count;
  logic signed [VAL_W-1:0] out_largest_value;

  ordered_store_shadow     shadow = new;
  int                      cycles = 0;
  int                      burst_left = 0;   // words left in a no-idle stretch

  // directed words, queued up front and replayed by the same driver
  logic                    plan_cmd[$];
  logic signed [VAL_W-1:0] plan_val[$];

  sorted_stack_insert_delete dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_command        (in_command),
    .in_operand_value  (in_operand_value),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_entry_count   (out_entry_count),
    .out_largest_value (out_largest_value)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop in case the block hangs or never answers
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Monitor: both sides sampled at the rising edge. The reply to a word comes
  // in the cycle after it is taken, so checking before noting is safe here.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid !== 1'b0)
        shadow.check_reply(out_status, out_entry_count, out_largest_value);
      if (start && busy === 1'b0)
        shadow.note_command(in_command, in_operand_value);
    end
  end

  function automatic void plan(input logic cmd, input logic signed [VAL_W-1:0] v);
    plan_cmd.push_back(cmd);
    plan_val.push_back(v);
  endfunction

  // mostly back-to-back, some short gaps, a few long ones, plus runs of
  // fifty or so words with no idling at all
  function automatic int pick_gap();
    int r;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      burst_left = $urandom_range(30, 70);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // small pool so duplicates and hits are common, extremes, and full range
  function automatic logic signed [VAL_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return $urandom_range(0, 8) - 4;
    if (r < 65) begin
      case ($urandom_range(0, 5))
        0:       return VAL_MAX;
        1:       return VAL_MIN;
        2:       return VAL_MAX - 1;
        3:       return VAL_MIN + 1;
        4:       return -1;
        default: return 0;
      endcase
    end
    return $urandom;
  endfunction

  // start low with junk on the fields, which the block must ignore
  task automatic idle_cycles(input int n);
    repeat (n) begin
      @(negedge clk);
      start            = 1'b0;
      in_command       = $urandom;
      in_operand_value = $urandom;
    end
  endtask

  // called just after a falling edge; returns at the edge that takes the word
  task automatic drive_word(input logic cmd, input logic signed [VAL_W-1:0] v);
    start            = 1'b1;
    in_command       = cmd;
    in_operand_value = v;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  initial begin
    int lean_insert;   // percent chance a random word is an insert
    int segment_left;
    logic cmd;
    logic signed [VAL_W-1:0] v;

    rst_n            = 1'b0;
    start            = 1'b0;
    in_command       = CMD_INSERT;
    in_operand_value = '0;
    lean_insert      = 50;
    segment_left     = 0;

    // directed: empty store, duplicates, extremes, full store
    plan(CMD_DELETE, 5);          // delete from empty
    plan(CMD_INSERT, 0);          // insert into empty
    plan(CMD_DELETE, 7);          // absent value
    plan(CMD_DELETE, 0);          // back to empty
    plan(CMD_INSERT, VAL_MAX);
    plan(CMD_INSERT, VAL_MIN);
    plan(CMD_INSERT, -1);
    plan(CMD_INSERT, -1);         // equal value lands above the first
    plan(CMD_INSERT, 1);
    plan(CMD_DELETE, -1);
    for (int i = 0; i < 12; i++)  // fill to the top, with more duplicates
      plan(CMD_INSERT, (i % 4 == 0) ? VAL_MAX : i * 1000 - 5000);
    plan(CMD_INSERT, 42);         // refused: store full
    plan(CMD_DELETE, VAL_MAX);    // topmost of several equal entries
    plan(CMD_DELETE, VAL_MIN);    // bottom entry

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (plan_cmd[i]) begin
      idle_cycles(pick_gap());
      @(negedge clk);
      drive_word(plan_cmd[i], plan_val[i]);
    end

    // random: segments that lean toward filling, draining, or neither, so the
    // store swings between empty and full many times
    for (int i = plan_cmd.size(); i < WORD_COUNT; i++) begin
      if (segment_left == 0) begin
        segment_left = $urandom_range(20, 60);
        case ($urandom_range(0, 2))
          0:       lean_insert = 85;
          1:       lean_insert = 15;
          default: lean_insert = 50;
        endcase
      end
      segment_left--;
      idle_cycles(pick_gap());
      @(negedge clk);
      // choose after the falling edge so the shadow has seen the last word
      cmd = ($urandom_range(0, 99) < lean_insert) ? CMD_INSERT : CMD_DELETE;
      if (cmd == CMD_DELETE && $urandom_range(0, 99) < 70)
        v = shadow.pick_held();
      else
        v = pick_value();
      drive_word(cmd, v);
    end

    @(negedge clk);
    start = 1'b0;

    // drain: each reply is registered in the cycle after its word, so the spare edges below are plenty
    while (shadow.awaited_replies.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    shadow.flag_leftovers();

    if (shadow.mismatches == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
